### rtl/core/owbm_pkg.sv
// Package for the 1-Wire bus master: item types, register indexes, reset values, helpers.
package owbm_pkg;

  // Command codes carried by an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Bus drive codes
  localparam logic [1:0] DRV_RELEASE = 2'd0;
  localparam logic [1:0] DRV_LOW     = 2'd1;
  localparam logic [1:0] DRV_HIGH    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_POLL_INTERVAL = 3'd1;
  localparam logic [2:0] REG_POLL_COUNT    = 3'd2;
  localparam logic [2:0] REG_WRITE_LOW     = 3'd3;
  localparam logic [2:0] REG_WRITE_HOLD    = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_TAIL     = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TickW    = 10;

  // Register reset values
  localparam logic [9:0] RST_RESET_LOW     = 10'd642;
  localparam logic [7:0] RST_POLL_INTERVAL = 8'd60;
  localparam logic [3:0] RST_POLL_COUNT    = 4'd6;
  localparam logic [7:0] RST_WRITE_LOW     = 8'd5;
  localparam logic [7:0] RST_WRITE_HOLD    = 8'd68;
  localparam logic [7:0] RST_READ_LOW      = 8'd4;
  localparam logic [7:0] RST_READ_SAMPLE   = 8'd9;
  localparam logic [7:0] RST_READ_TAIL     = 8'd51;

  localparam int unsigned RECOVERY_TICKS_DEFAULT = 4;

  // Sequencer phases, one-hot
  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_POLL = 10'b00_0000_0100,
    PH_WR_LOW   = 10'b00_0000_1000,
    PH_WR_HOLD  = 10'b00_0001_0000,
    PH_WR_REC   = 10'b00_0010_0000,
    PH_RD_LOW   = 10'b00_0100_0000,
    PH_RD_WAIT  = 10'b00_1000_0000,
    PH_RD_SAMP  = 10'b01_0000_0000,
    PH_RD_TAIL  = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] bus_drive;
    logic       busy_res;
    logic       done_res;
    logic       presence_found;
    logic [7:0] read_data;
  } out_item_t;

  // A duration of zero counts as one tick
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

### rtl/core/one_wire_bus_master.sv
// 1-Wire bus master: reset/presence, byte write and byte read sequencer, one tick per item.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o    | in_item_i   (in_item_t)
//  out     | output    | out_valid_o / out_stall_i  | out_item_o  (out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each input item is one bus tick and yields one registered result item in the cycle after it is taken.
// The sequencer state and the result register update in the same cycle, so an
// item is taken every cycle while the result register is empty or being drained.
// Reset (rst_ni, async) returns the sequencer to idle and loads register defaults.
// in_stall_o rises only while a result is held and out_stall_i is high.
module one_wire_bus_master import owbm_pkg::*; #(
  parameter int unsigned RECOVERY_TICKS = RECOVERY_TICKS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [TickW-1:0] RecTicks = TickW'(RECOVERY_TICKS);

  // Configuration registers
  logic [9:0] reset_low_q;
  logic [7:0] poll_interval_q, write_low_q, write_hold_q;
  logic [7:0] read_low_q, read_sample_q, read_tail_q;
  logic [3:0] poll_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q     <= RST_RESET_LOW;
      poll_interval_q <= RST_POLL_INTERVAL;
      poll_count_q    <= RST_POLL_COUNT;
      write_low_q     <= RST_WRITE_LOW;
      write_hold_q    <= RST_WRITE_HOLD;
      read_low_q      <= RST_READ_LOW;
      read_sample_q   <= RST_READ_SAMPLE;
      read_tail_q     <= RST_READ_TAIL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RESET_LOW:     reset_low_q     <= cfg_data_i;
        REG_POLL_INTERVAL: poll_interval_q <= cfg_data_i[7:0];
        REG_POLL_COUNT:    poll_count_q    <= cfg_data_i[3:0];
        REG_WRITE_LOW:     write_low_q     <= cfg_data_i[7:0];
        REG_WRITE_HOLD:    write_hold_q    <= cfg_data_i[7:0];
        REG_READ_LOW:      read_low_q      <= cfg_data_i[7:0];
        REG_READ_SAMPLE:   read_sample_q   <= cfg_data_i[7:0];
        REG_READ_TAIL:     read_tail_q     <= cfg_data_i[7:0];
        default:           ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Sequencer state
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [3:0]       poll_q, poll_d;
  out_item_t        res_q, res_d;

  // Next state and result for one tick
  always_comb begin
    phase_e           ph;
    logic [TickW-1:0] tc;
    logic [2:0]       bi;
    logic [7:0]       sb;
    logic [3:0]       pi;
    ph = phase_q;
    tc = tick_q;
    bi = bit_q;
    sb = shift_q;
    pi = poll_q;
    res_d = '0;

    // Command start, taken only while idle
    if (ph == PH_IDLE) begin
      unique case (in_item_i.cmd)
        CMD_RESET: begin
          ph = PH_RST_LOW;
          tc = at_least_one(reset_low_q);
          pi = '0;
        end
        CMD_WRITE: begin
          ph = PH_WR_LOW;
          tc = at_least_one({2'b00, write_low_q});
          sb = in_item_i.data_byte;
          bi = '0;
        end
        CMD_READ: begin
          ph = PH_RD_LOW;
          tc = at_least_one({2'b00, read_low_q});
          sb = '0;
          bi = '0;
        end
        default: ;
      endcase
    end

    if (ph != PH_IDLE) begin
      res_d.busy_res = 1'b1;
      unique case (ph)
        PH_RST_LOW: begin
          res_d.bus_drive = DRV_LOW;
          tc = tc - TickW'(1);
          if (tc == '0) ph = PH_RST_POLL;
        end
        PH_RST_POLL: begin
          res_d.bus_drive = DRV_RELEASE;
          if (tc == '0) begin
            if (pi >= poll_count_q) begin
              res_d.done_res = 1'b1;
              ph = PH_IDLE;
            end else if (!in_item_i.bus_level) begin
              res_d.done_res       = 1'b1;
              res_d.presence_found = 1'b1;
              ph = PH_IDLE;
            end else begin
              pi = pi + 4'd1;
              tc = at_least_one({2'b00, poll_interval_q}) - TickW'(1);
            end
          end else begin
            tc = tc - TickW'(1);
          end
        end
        PH_WR_LOW: begin
          res_d.bus_drive = DRV_LOW;
          tc = tc - TickW'(1);
          if (tc == '0) begin
            ph = PH_WR_HOLD;
            tc = at_least_one({2'b00, write_hold_q});
          end
        end
        PH_WR_HOLD: begin
          res_d.bus_drive = sb[0] ? DRV_HIGH : DRV_LOW;
          tc = tc - TickW'(1);
          if (tc == '0) begin
            sb = {1'b0, sb[7:1]};
            ph = PH_WR_REC;
            tc = at_least_one(RecTicks);
          end
        end
        PH_WR_REC: begin
          res_d.bus_drive = DRV_RELEASE;
          tc = tc - TickW'(1);
          if (tc == '0) begin
            if (bi == 3'd7) begin
              res_d.done_res = 1'b1;
              ph = PH_IDLE;
            end else begin
              bi = bi + 3'd1;
              ph = PH_WR_LOW;
              tc = at_least_one({2'b00, write_low_q});
            end
          end
        end
        PH_RD_LOW: begin
          res_d.bus_drive = DRV_LOW;
          tc = tc - TickW'(1);
          if (tc == '0) begin
            ph = PH_RD_WAIT;
            tc = at_least_one({2'b00, read_sample_q});
          end
        end
        PH_RD_WAIT: begin
          res_d.bus_drive = DRV_RELEASE;
          tc = tc - TickW'(1);
          if (tc == '0) ph = PH_RD_SAMP;
        end
        PH_RD_SAMP: begin
          res_d.bus_drive = DRV_RELEASE;
          sb = {in_item_i.bus_level, sb[7:1]};
          ph = PH_RD_TAIL;
          tc = at_least_one({2'b00, read_tail_q});
        end
        PH_RD_TAIL: begin
          res_d.bus_drive = DRV_RELEASE;
          tc = tc - TickW'(1);
          if (tc == '0) begin
            if (bi == 3'd7) begin
              res_d.done_res  = 1'b1;
              res_d.read_data = sb;
              ph = PH_IDLE;
            end else begin
              bi = bi + 3'd1;
              ph = PH_RD_LOW;
              tc = at_least_one({2'b00, read_low_q});
            end
          end
        end
        default: begin
          // illegal phase code: recover to idle
          ph = PH_IDLE;
          res_d.busy_res = 1'b0;
        end
      endcase
    end

    phase_d = ph;
    tick_d  = tc;
    bit_d   = bi;
    shift_d = sb;
    poll_d  = pi;
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      poll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        poll_q  <= poll_d;
      end
      if (in_acc) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  assign out_item_o = res_q;

  // Assertions
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> res_q.busy_res)
    else $error("done without busy");

  a_pres_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.presence_found |-> res_q.done_res)
    else $error("presence outside completion");

  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.read_data != '0) |-> res_q.done_res)
    else $error("read data outside completion");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the 1-Wire bus master: directed slot timing plus random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import owbm_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  one_wire_bus_master u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copy held by the sequencer model
  logic [9:0] cfg_rst_low;
  logic [7:0] cfg_poll_gap;
  logic [3:0] cfg_poll_num;
  logic [7:0] cfg_wr_low;
  logic [7:0] cfg_wr_hold;
  logic [7:0] cfg_rd_low;
  logic [7:0] cfg_rd_wait;
  logic [7:0] cfg_rd_tail;

  // Sequencer model state
  phase_e     seq_phase;
  logic [9:0] ticks_left;
  logic [2:0] bit_pos;
  logic [7:0] shreg;
  logic [3:0] polls_done;

  out_item_t  bus_tick_due[$];
  out_item_t  want_item;
  logic [9:0] reg_plan[8];

  // Bus answers for the operation in flight
  int unsigned answer_at;
  logic [7:0]  read_pattern;

  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  int unsigned n_resets = 0;
  int unsigned n_present = 0;
  int unsigned n_writes = 0;
  int unsigned n_reads = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  // A programmed duration of zero still lasts one tick
  function automatic logic [9:0] ticks_of(logic [9:0] v);
    return {v[9:1], v[0] | ~|v};
  endfunction

  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    case (idx)
      REG_RESET_LOW:     cfg_rst_low  = v[9:0];
      REG_POLL_INTERVAL: cfg_poll_gap = v[7:0];
      REG_POLL_COUNT:    cfg_poll_num = v[3:0];
      REG_WRITE_LOW:     cfg_wr_low   = v[7:0];
      REG_WRITE_HOLD:    cfg_wr_hold  = v[7:0];
      REG_READ_LOW:      cfg_rd_low   = v[7:0];
      REG_READ_SAMPLE:   cfg_rd_wait  = v[7:0];
      default:           cfg_rd_tail  = v[7:0];
    endcase
  endfunction

  // One bus tick of the sequencer: returns the result item it should produce
  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t r;
    r = '0;
    if (seq_phase == PH_IDLE) begin
      case (it.cmd)
        CMD_RESET: begin
          seq_phase  = PH_RST_LOW;
          ticks_left = ticks_of(cfg_rst_low);
          polls_done = '0;
        end
        CMD_WRITE: begin
          seq_phase  = PH_WR_LOW;
          ticks_left = ticks_of(10'(cfg_wr_low));
          shreg      = it.data_byte;
          bit_pos    = '0;
        end
        CMD_READ: begin
          seq_phase  = PH_RD_LOW;
          ticks_left = ticks_of(10'(cfg_rd_low));
          shreg      = '0;
          bit_pos    = '0;
        end
        default: ;
      endcase
    end
    if (seq_phase == PH_IDLE) return r;
    r.busy_res = 1'b1;
    case (seq_phase)
      PH_RST_LOW: begin
        r.bus_drive = DRV_LOW;
        ticks_left--;
        if (ticks_left == '0) seq_phase = PH_RST_POLL;
      end
      PH_RST_POLL: begin
        r.bus_drive = DRV_RELEASE;
        if (ticks_left != '0) begin
          ticks_left--;
        end else if (polls_done >= cfg_poll_num) begin
          r.done_res = 1'b1;
          seq_phase  = PH_IDLE;
          n_resets++;
        end else if (!it.bus_level) begin
          r.done_res       = 1'b1;
          r.presence_found = 1'b1;
          seq_phase        = PH_IDLE;
          n_resets++;
          n_present++;
        end else begin
          polls_done++;
          ticks_left = ticks_of(10'(cfg_poll_gap)) - 10'd1;
        end
      end
      PH_WR_LOW: begin
        r.bus_drive = DRV_LOW;
        ticks_left--;
        if (ticks_left == '0) begin
          seq_phase  = PH_WR_HOLD;
          ticks_left = ticks_of(10'(cfg_wr_hold));
        end
      end
      PH_WR_HOLD: begin
        r.bus_drive = shreg[0] ? DRV_HIGH : DRV_LOW;
        ticks_left--;
        if (ticks_left == '0) begin
          shreg      = shreg >> 1;
          seq_phase  = PH_WR_REC;
          ticks_left = ticks_of(10'(RECOVERY_TICKS_DEFAULT));
        end
      end
      PH_WR_REC: begin
        r.bus_drive = DRV_RELEASE;
        ticks_left--;
        if (ticks_left == '0) begin
          if (bit_pos == 3'd7) begin
            r.done_res = 1'b1;
            seq_phase  = PH_IDLE;
            n_writes++;
          end else begin
            bit_pos++;
            seq_phase  = PH_WR_LOW;
            ticks_left = ticks_of(10'(cfg_wr_low));
          end
        end
      end
      PH_RD_LOW: begin
        r.bus_drive = DRV_LOW;
        ticks_left--;
        if (ticks_left == '0) begin
          seq_phase  = PH_RD_WAIT;
          ticks_left = ticks_of(10'(cfg_rd_wait));
        end
      end
      PH_RD_WAIT: begin
        r.bus_drive = DRV_RELEASE;
        ticks_left--;
        if (ticks_left == '0) seq_phase = PH_RD_SAMP;
      end
      PH_RD_SAMP: begin
        r.bus_drive = DRV_RELEASE;
        shreg       = {it.bus_level, shreg[7:1]};
        seq_phase   = PH_RD_TAIL;
        ticks_left  = ticks_of(10'(cfg_rd_tail));
      end
      default: begin
        r.bus_drive = DRV_RELEASE;
        ticks_left--;
        if (ticks_left == '0) begin
          if (bit_pos == 3'd7) begin
            r.done_res  = 1'b1;
            r.read_data = shreg;
            seq_phase   = PH_IDLE;
            n_reads++;
          end else begin
            bit_pos++;
            seq_phase  = PH_RD_LOW;
            ticks_left = ticks_of(10'(cfg_rd_low));
          end
        end
      end
    endcase
    return r;
  endfunction

  // Level a well-behaved device puts on the bus for the coming tick
  function automatic logic level_for_tick();
    if (seq_phase == PH_RST_POLL && ticks_left == '0) return (polls_done == answer_at) ? 1'b0 : 1'b1;
    if (seq_phase == PH_RD_SAMP) return read_pattern[bit_pos];
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_tick_due.size() == 0) begin
        $error("result item with nothing outstanding");
        n_errors++;
      end else begin
        want_item = bus_tick_due.pop_front();
        check_field("bus_drive", 8'(want_item.bus_drive), 8'(out_item_o.bus_drive));
        check_field("busy_res", 8'(want_item.busy_res), 8'(out_item_o.busy_res));
        check_field("done_res", 8'(want_item.done_res), 8'(out_item_o.done_res));
        check_field("presence_found", 8'(want_item.presence_found),
                    8'(out_item_o.presence_found));
        check_field("read_data", want_item.read_data, out_item_o.read_data);
      end
    end
  end

  // Receiver back-pressure: modes of free flow, light, heavy and alternating stall
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // Send one tick item, with random bursts and gaps on the sender side
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    bus_tick_due.push_back(step_sequencer(it));
  endtask

  // Issue a command and keep ticking until the sequencer is idle again
  task automatic run_op(logic [1:0] cmd, logic [7:0] wbyte, logic [7:0] rbyte,
                        int unsigned answer, bit noisy);
    in_item_t it;
    answer_at    = answer;
    read_pattern = rbyte;
    it.cmd       = cmd;
    it.data_byte = wbyte;
    it.bus_level = level_for_tick();
    send_item(it);
    while (seq_phase != PH_IDLE) begin
      // commands here arrive while busy and must be ignored
      it.cmd       = 2'($urandom_range(0, 3));
      it.data_byte = 8'($urandom);
      it.bus_level = level_for_tick();
      if (noisy && $urandom_range(0, 7) == 0) it.bus_level = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  // Hold off the sender until every outstanding result has drained
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bus_tick_due.size() != 0) @(posedge clk_i);
  endtask

  // Write all eight registers from reg_plan; block is idle
  task automatic load_registers();
    for (int i = 0; i < $size(reg_plan); i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= reg_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_register(CfgIdxW'(i), reg_plan[i]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic plan_uniform(logic [9:0] v, logic [3:0] polls);
    foreach (reg_plan[i]) reg_plan[i] = v;
    reg_plan[REG_POLL_COUNT] = 10'(polls);
  endtask

  function automatic logic [9:0] rand_duration(int unsigned bits);
    case ($urandom_range(0, 19))
      0:       return 10'($urandom_range(0, (1 << bits) - 1));
      1, 2, 3: return 10'($urandom_range(5, 24));
      default: return 10'($urandom_range(0, 4));
    endcase
  endfunction

  // Reset values: an idle tick and one full byte read
  task automatic test_default_timing();
    run_op(CMD_TICK, 8'hFF, 8'h00, 0, 1'b0);
    run_op(CMD_READ, 8'h00, 8'hA5, 0, 1'b0);
    drain();
  endtask

  // One-tick durations, then zero durations and a zero poll count
  task automatic test_shortest_slots();
    plan_uniform(10'd1, 4'd1);
    load_registers();
    run_op(CMD_RESET, 8'h00, 8'h00, 0, 1'b0);
    run_op(CMD_RESET, 8'h00, 8'h00, 16, 1'b0);
    run_op(CMD_WRITE, 8'h3C, 8'h00, 0, 1'b0);
    run_op(CMD_READ, 8'h00, 8'hC3, 0, 1'b0);
    drain();
    plan_uniform(10'd0, 4'd0);
    load_registers();
    run_op(CMD_RESET, 8'h00, 8'h00, 0, 1'b0);
    run_op(CMD_WRITE, 8'h81, 8'h00, 0, 1'b0);
    run_op(CMD_READ, 8'h00, 8'h7E, 0, 1'b0);
    drain();
  endtask

  // Mostly well-formed operations with random content, some noisy bus levels
  task automatic test_random_traffic();
    int unsigned ops;
    logic [1:0]  cmd;
    ops = 0;
    while (n_items < 850 || ops < 6) begin
      if (ops % 2 == 0) begin
        drain();
        reg_plan[REG_RESET_LOW]     = rand_duration(10);
        reg_plan[REG_POLL_INTERVAL] = rand_duration(8);
        reg_plan[REG_POLL_COUNT]    = ($urandom_range(0, 4) == 0) ?
                                      10'($urandom_range(0, 15)) : 10'($urandom_range(0, 4));
        reg_plan[REG_WRITE_LOW]     = rand_duration(8);
        reg_plan[REG_WRITE_HOLD]    = rand_duration(8);
        reg_plan[REG_READ_LOW]      = rand_duration(8);
        reg_plan[REG_READ_SAMPLE]   = rand_duration(8);
        reg_plan[REG_READ_TAIL]     = rand_duration(8);
        load_registers();
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          run_op(CMD_TICK, 8'($urandom), 8'h00, 0, 1'b0);
      end
      case ($urandom_range(0, 2))
        0:       cmd = CMD_RESET;
        1:       cmd = CMD_WRITE;
        default: cmd = CMD_READ;
      endcase
      run_op(cmd, 8'($urandom), 8'($urandom), $urandom_range(0, 32'(cfg_poll_num) + 1),
             $urandom_range(0, 5) == 0);
      ops++;
    end
    drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    cfg_rst_low  = RST_RESET_LOW;
    cfg_poll_gap = RST_POLL_INTERVAL;
    cfg_poll_num = RST_POLL_COUNT;
    cfg_wr_low   = RST_WRITE_LOW;
    cfg_wr_hold  = RST_WRITE_HOLD;
    cfg_rd_low   = RST_READ_LOW;
    cfg_rd_wait  = RST_READ_SAMPLE;
    cfg_rd_tail  = RST_READ_TAIL;
    seq_phase    = PH_IDLE;
    ticks_left   = '0;
    bit_pos      = '0;
    shreg        = '0;
    polls_done   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_timing();
    test_shortest_slots();
    test_random_traffic();

    drain();
    repeat (4) @(posedge clk_i);
    $display("covered %0d resets (%0d answered), %0d byte writes, %0d byte reads",
             n_resets, n_present, n_writes, n_reads);
    $display("%0d bus ticks checked across %0d register settings", n_items, n_settings);
    if (n_errors == 0) begin
      $display("[one_wire_bus_master] OK");
    end else begin
      $display("[one_wire_bus_master] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("[one_wire_bus_master] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/owbm_pkg.sv
rtl/core/one_wire_bus_master.sv
tb/sv/testbench.sv
